// ===== hdl/gscc_pkg.sv =====
// Shared types and constants for the grid small cluster cleaner.
// No dependencies; imported by gscc_clean, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package gscc_pkg;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;
  localparam int DIM_W        = 9;
  localparam int CELL_OUT_W   = 7;
  localparam logic [CELL_OUT_W-1:0] CELL_OCC  = CELL_OUT_W'(100);
  localparam logic [CELL_OUT_W-1:0] CELL_FREE = '0;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_CLEAN = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [0:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_RD_TGT, SQ_TGT_W, SQ_RD_CELL, SQ_CELL_W, SQ_TRY,
    SQ_RD_RING, SQ_RING_W, SQ_FILL, SQ_FAIL, SQ_ADV, SQ_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    SH_1X1, SH_1X2, SH_2X1, SH_2X2
  } shape_t;

  // memory port controls driven by the clean sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_data;
  } mem_ctl_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw,
                                               input int max_dim);
    logic [DIM_W-1:0] res;
    res = raw;
    if (raw == '0) res = DIM_W'(1);
    else if (int'(raw) > max_dim) res = DIM_W'(max_dim);
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/gscc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gscc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== hdl/gscc_clean.sv =====
// Clean pass sequencer: walks interior cells, checks rings and fills shapes
// through read-modify-write of the occupancy RAM. Depends on gscc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gscc_clean import gscc_pkg::*; #(
  parameter int AW = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIM_W-1:0] rows,
  input  wire logic [DIM_W-1:0] cols,
  input  wire logic             rd_data,
  output mem_ctl_t              mem_ctl,
  output logic      [AW-1:0]    rd_addr,
  output logic      [AW-1:0]    wr_addr,
  output logic                  busy,
  output logic                  done
);
  seq_state_t state, state_next;
  shape_t shape;
  logic [DIM_W-1:0] r, c;
  logic [AW-1:0] row_addr, ring_row;
  logic [1:0] dr, dc, fi, h, w;
  logic tgt, cur;
  logic in_blk, last, fits, fill_ok, row_more, col_more;
  logic [DIM_W:0] r_ext, c_ext;

  assign h = (shape == SH_2X1 || shape == SH_2X2) ? 2'd2 : 2'd1;
  assign w = (shape == SH_1X2 || shape == SH_2X2) ? 2'd2 : 2'd1;
  assign r_ext = {1'b0, r};
  assign c_ext = {1'b0, c};
  assign in_blk = dr >= 2'd1 && dr <= h && dc >= 2'd1 && dc <= w;
  assign last = (dc == w + 2'd1) && (dr == h + 2'd1);
  // block plus ring must stay inside the grid
  assign fits = (r_ext + {8'd0, h} + 10'd1 <= {1'b0, rows})
             && (c_ext + {8'd0, w} + 10'd1 <= {1'b0, cols});
  assign fill_ok = ({1'b0, fi[1]} < h) && ({1'b0, fi[0]} < w);
  assign col_more = c_ext + 10'd2 < {1'b0, cols};
  assign row_more = r_ext + 10'd2 < {1'b0, rows};

  always_comb begin
    state_next = state;
    unique case (state)
      SQ_IDLE:    if (start) state_next = (rows < DIM_W'(3) || cols < DIM_W'(3))
                                          ? SQ_DONE : SQ_RD_TGT;
      SQ_RD_TGT:  state_next = SQ_TGT_W;
      SQ_TGT_W:   state_next = SQ_RD_CELL;
      SQ_RD_CELL: state_next = SQ_CELL_W;
      SQ_CELL_W:  state_next = (rd_data == tgt) ? SQ_ADV : SQ_TRY;
      SQ_TRY:     state_next = fits ? SQ_RD_RING : SQ_FAIL;
      SQ_RD_RING: state_next = in_blk ? SQ_RD_RING : SQ_RING_W;
      SQ_RING_W:  state_next = (rd_data != tgt) ? SQ_FAIL : (last ? SQ_FILL : SQ_RD_RING);
      SQ_FILL:    state_next = (fi == 2'd3) ? SQ_ADV : SQ_FILL;
      SQ_FAIL:    state_next = (shape == SH_2X2) ? SQ_ADV : SQ_TRY;
      SQ_ADV:     state_next = col_more ? SQ_RD_CELL : (row_more ? SQ_RD_TGT : SQ_DONE);
      SQ_DONE:    state_next = SQ_IDLE;
      default:    state_next = SQ_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl = '0;
    rd_addr = row_addr;
    wr_addr = row_addr + (fi[1] ? AW'(cols) : '0) + AW'(c) + AW'(fi[0]);
    unique case (state)
      SQ_RD_CELL: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr = row_addr + AW'(c);
      end
      SQ_RD_TGT:  mem_ctl.rd_en = 1'b1;
      SQ_RD_RING: begin
        mem_ctl.rd_en = !in_blk;
        rd_addr = ring_row + AW'(c) - AW'(1) + AW'(dc);
      end
      SQ_FILL: begin
        mem_ctl.wr_en   = fill_ok;
        mem_ctl.wr_data = tgt;
      end
      default: ;
    endcase
    busy = state != SQ_IDLE;
    done = state == SQ_DONE;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= SQ_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      SQ_IDLE: begin
        r <= DIM_W'(1);
        row_addr <= AW'(cols);
      end
      SQ_TGT_W: begin
        tgt <= rd_data;
        c <= DIM_W'(1);
      end
      SQ_CELL_W: begin
        cur <= rd_data;
        shape <= SH_1X1;
      end
      SQ_TRY: begin
        dr <= 2'd0;
        dc <= 2'd0;
        ring_row <= row_addr - AW'(cols);
      end
      SQ_RD_RING, SQ_RING_W: begin
        // step the ring walk after a skipped inner cell or a matching read
        if ((state == SQ_RD_RING && in_blk) || (state == SQ_RING_W && !last)) begin
          if (dc == w + 2'd1) begin
            dc <= 2'd0;
            dr <= dr + 2'd1;
            ring_row <= ring_row + AW'(cols);
          end else begin
            dc <= dc + 2'd1;
          end
        end
        fi <= 2'd0;
      end
      SQ_FILL: fi <= fi + 2'd1;
      SQ_FAIL: begin
        if (shape == SH_2X2) tgt <= cur;
        else shape <= shape_t'(shape + 2'd1);
      end
      SQ_ADV: begin
        if (col_more) begin
          c <= c + DIM_W'(1);
        end else begin
          r <= r + DIM_W'(1);
          row_addr <= row_addr + AW'(cols);
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/grid_small_cluster_cleaner_top.sv =====
// Top level of the grid small cluster cleaner: stream ports, config
// registers, positions and output register. Depends on gscc_pkg, gscc_ram,
// gscc_clean.
//
// Usage: set grid_rows / grid_cols (cfg index 0 / 1) while idle, then send
// beats on the s_ side. s_tuser carries the request kind: load writes the
// next cell in raster order and returns nothing; read returns the next cell
// as 0 or 100 with m_tuser low; clean runs the cleaning pass and returns one
// beat with m_tuser high and zero data, rewinding both positions.
// Load and read take one beat per cycle while s_tready is high; a read result
// passes through the RAM output register and then the output register before
// it appears on m_. The clean pass holds s_tready low while the sequencer
// walks the grid: it reads the reference once per row, then each interior cell,
// and for a differing cell tries the shapes in turn, checking ring cells, skipping
// block cells and filling; all reads share the single read port of the occupancy RAM.
// When m_tready is low one result is held in the output register and one
// in the RAM output; further reads then stall s_tready.
// Reset clears control state, positions and sets both dimensions to 256;
// the grid contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module grid_small_cluster_cleaner_top import gscc_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // [7:0] cell_value
  input  wire logic [1:0]       s_tuser,   // [1:0] req_type
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [7:0]       m_tdata,   // [6:0] cell_out, [7] zero fill
  output logic                  m_tuser,   // [0] clean_done
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data
);
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);

  logic [DIM_W-1:0] grid_rows, grid_cols, rows, cols;
  logic [AW:0] total;
  logic [AW-1:0] load_pos, read_pos, load_use, read_use, load_inc, read_inc;
  logic pend, done_pend, out_free, acc, busy, seq_done, rd_data;
  logic [CELL_OUT_W-1:0] cell_out;
  logic clean_done;
  req_t req;
  mem_ctl_t seq_ctl;
  logic [AW-1:0] seq_rd_addr, seq_wr_addr;
  logic ram_wr_en, ram_wr_data, ram_rd_en;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;

  assign rows = eff_dim(grid_rows, MAX_ROWS);
  assign cols = eff_dim(grid_cols, MAX_COLS);
  assign total = (AW+1)'(rows) * (AW+1)'(cols);
  assign req = req_t'(s_tuser);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !busy && !done_pend && (!pend || out_free);
  assign acc = s_tvalid && s_tready;

  assign load_use = ({1'b0, load_pos} >= total) ? '0 : load_pos;
  assign read_use = ({1'b0, read_pos} >= total) ? '0 : read_pos;
  assign load_inc = (({1'b0, load_use} + (AW+1)'(1)) >= total) ? '0 : load_use + AW'(1);
  assign read_inc = (({1'b0, read_use} + (AW+1)'(1)) >= total) ? '0 : read_use + AW'(1);

  always_comb begin
    ram_wr_en = acc && req == REQ_LOAD;
    ram_wr_addr = load_use;
    ram_wr_data = s_tdata != 8'd0;
    ram_rd_en = acc && req == REQ_READ;
    ram_rd_addr = read_use;
    if (busy) begin
      ram_wr_en = seq_ctl.wr_en;
      ram_wr_addr = seq_wr_addr;
      ram_wr_data = seq_ctl.wr_data;
      ram_rd_en = seq_ctl.rd_en;
      ram_rd_addr = seq_rd_addr;
    end
  end

  gscc_ram #(.WIDTH(1), .DEPTH(MAX_ROWS * MAX_COLS)) u_ram (
    .clk(clk), .wr_en(ram_wr_en), .wr_addr(ram_wr_addr), .wr_data(ram_wr_data),
    .rd_en(ram_rd_en), .rd_addr(ram_rd_addr), .rd_data(rd_data)
  );

  gscc_clean #(.AW(AW)) u_clean (
    .clk(clk), .rst(rst), .start(acc && req == REQ_CLEAN),
    .rows(rows), .cols(cols), .rd_data(rd_data), .mem_ctl(seq_ctl),
    .rd_addr(seq_rd_addr), .wr_addr(seq_wr_addr), .busy(busy), .done(seq_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= DIM_W'(256);
      grid_cols <= DIM_W'(256);
      load_pos <= '0;
      read_pos <= '0;
      pend <= 1'b0;
      done_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ROWS: grid_rows <= cfg_data;
          CFG_COLS: grid_cols <= cfg_data;
          default: ;
        endcase
      end
      // move a landed read or the clean acknowledge into the output register
      pend <= (acc && req == REQ_READ) || (pend && !out_free);
      done_pend <= seq_done || (done_pend && !(out_free && !pend));
      if (out_free) m_tvalid <= pend || done_pend;
      if (acc) begin
        unique case (req)
          REQ_LOAD:  load_pos <= load_inc;
          REQ_READ:  read_pos <= read_inc;
          REQ_CLEAN: begin
            load_pos <= '0;
            read_pos <= '0;
          end
          REQ_NONE: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend) begin
        cell_out <= rd_data ? CELL_OCC : CELL_FREE;
        clean_done <= 1'b0;
      end else if (done_pend) begin
        cell_out <= CELL_FREE;
        clean_done <= 1'b1;
      end
    end
  end

  assign m_tdata = {1'b0, cell_out};
  assign m_tuser = clean_done;
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for grid_small_cluster_cleaner_top: directed table, then random
// phases over several grid sizes, all results checked against an in-bench grid predictor.
// Depends on gscc_pkg and the RTL under hdl/.
`timescale 1ns / 1ps
module tb_top;
  import gscc_pkg::*;

  localparam int CELLS      = DEF_MAX_ROWS * DEF_MAX_COLS;
  localparam int IDLE_LIMIT = 400000;
  localparam int SETTLE     = 50;

  typedef struct {
    logic [CELL_OUT_W-1:0] cell_val;
    logic                  done;
  } grid_beat_t;

  typedef struct {
    req_t                  req;
    logic [7:0]            val;
    bit                    typed;
    logic [CELL_OUT_W-1:0] cell_val;
    logic                  done;
  } dir_row_t;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  s_tvalid = 0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic [1:0]            s_tuser = REQ_LOAD;
  logic                  m_tvalid;
  logic                  m_tready = 0;
  logic [7:0]            m_tdata;
  logic                  m_tuser;
  logic                  cfg_wr_en = 0;
  logic                  cfg_index = CFG_ROWS;
  logic [DIM_W-1:0]      cfg_data = '0;

  grid_small_cluster_cleaner_top uut (.*);

  always #1 clk = ~clk;

  // predictor state
  bit             occ_grid [CELLS];
  bit             loaded   [CELLS];
  int unsigned    rows_reg = 256, cols_reg = 256;
  int unsigned    load_pos = 0, read_pos = 0;
  grid_beat_t     expected_beats [$];
  int             fail_count = 0;
  bit             calm = 0;
  int             density = 20;
  int             hold_requests = 0;
  bit             hold_next = 0;

  function automatic int unsigned clamp_dim(int unsigned raw);
    if (raw == 0) return 1;
    return raw > 256 ? 256 : raw;
  endfunction

  function automatic bit ring_fill(int unsigned r, int unsigned c, int unsigned h,
                                   int unsigned w, int unsigned rows, int unsigned cols,
                                   bit ref_val);
    bit in_shape;
    if (r + h > rows - 1 || c + w > cols - 1) return 0;
    for (int unsigned rr = r - 1; rr <= r + h; rr++)
      for (int unsigned cc = c - 1; cc <= c + w; cc++) begin
        in_shape = rr >= r && rr < r + h && cc >= c && cc < c + w;
        if (!in_shape && occ_grid[rr * cols + cc] != ref_val) return 0;
      end
    for (int unsigned rr = r; rr < r + h; rr++)
      for (int unsigned cc = c; cc < c + w; cc++)
        occ_grid[rr * cols + cc] = ref_val;
    return 1;
  endfunction

  function automatic void clean_grid(int unsigned rows, int unsigned cols);
    bit ref_val;
    if (rows < 3 || cols < 3) return;
    for (int unsigned r = 1; r + 1 < rows; r++) begin
      ref_val = occ_grid[r * cols];
      for (int unsigned c = 1; c + 1 < cols; c++) begin
        if (occ_grid[r * cols + c] == ref_val) continue;
        if (ring_fill(r, c, 1, 1, rows, cols, ref_val)) continue;
        if (ring_fill(r, c, 1, 2, rows, cols, ref_val)) continue;
        if (ring_fill(r, c, 2, 1, rows, cols, ref_val)) continue;
        if (ring_fill(r, c, 2, 2, rows, cols, ref_val)) continue;
        ref_val = occ_grid[r * cols + c];
      end
    end
  endfunction

  // advance the grid by one accepted request, queue any result it causes
  function automatic void grid_step(req_t req, logic [7:0] val);
    int unsigned rows, cols, total;
    grid_beat_t b;
    rows  = clamp_dim(rows_reg);
    cols  = clamp_dim(cols_reg);
    total = rows * cols;
    case (req)
      REQ_LOAD: begin
        if (load_pos >= total) load_pos = 0;
        occ_grid[load_pos] = val != 0;
        loaded[load_pos] = 1;
        load_pos++;
        if (load_pos >= total) load_pos = 0;
      end
      REQ_CLEAN: begin
        clean_grid(rows, cols);
        load_pos = 0;
        read_pos = 0;
        b.cell_val = CELL_FREE;
        b.done = 1;
        expected_beats.push_back(b);
      end
      REQ_READ: begin
        if (read_pos >= total) read_pos = 0;
        b.cell_val = occ_grid[read_pos] ? CELL_OCC : CELL_FREE;
        b.done = 0;
        expected_beats.push_back(b);
        read_pos++;
        if (read_pos >= total) read_pos = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic bit grid_loaded();
    int unsigned total;
    total = clamp_dim(rows_reg) * clamp_dim(cols_reg);
    for (int unsigned i = 0; i < total; i++)
      if (!loaded[i]) return 0;
    return 1;
  endfunction

  function automatic int draw_gap();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  // offer one beat; returns at the falling edge after acceptance
  task automatic send_beat(req_t req, logic [7:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1;
    s_tuser  = req;
    s_tdata  = val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    grid_step(req, val);
    @(negedge clk);
  endtask

  // the result of the row just sent is still at the back of the queue
  task automatic send_typed(dir_row_t row);
    int n;
    send_beat(row.req, row.val);
    n = expected_beats.size() - 1;
    if (row.typed && (row.req == REQ_READ || row.req == REQ_CLEAN)) begin
      expected_beats[n].cell_val = row.cell_val;
      expected_beats[n].done = row.done;
    end
  endtask

  task automatic write_dims(int unsigned rows, int unsigned cols);
    s_tvalid = 0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en = 1;
    cfg_index = CFG_ROWS;
    cfg_data  = DIM_W'(rows);
    @(negedge clk);
    cfg_index = CFG_COLS;
    cfg_data  = DIM_W'(cols);
    @(negedge clk);
    cfg_wr_en = 0;
    rows_reg = rows;
    cols_reg = cols;
  endtask

  function automatic logic [7:0] draw_cell();
    if ($urandom_range(0, 99) < density) return 8'($urandom_range(1, 255));
    return 8'h00;
  endfunction

  task automatic run_phase(int unsigned rows, int unsigned cols, int beats);
    int pick;
    write_dims(rows, cols);
    density = $urandom_range(0, 1) ? $urandom_range(5, 25) : $urandom_range(75, 95);
    while (!grid_loaded()) send_beat(REQ_LOAD, draw_cell());
    // long receiver hold-off while beats keep coming
    if (hold_next) begin
      hold_requests++;
      hold_next = 0;
    end
    for (int i = 0; i < beats; i++) begin
      pick = $urandom_range(0, 99);
      if (i % 40 == 0) calm = $urandom_range(0, 2) == 0;
      if (pick < 45)      send_beat(REQ_LOAD, draw_cell());
      else if (pick < 85) send_beat(REQ_READ, 8'($urandom));
      else if (pick < 94) send_beat(REQ_CLEAN, 8'($urandom));
      else                send_beat(REQ_NONE, 8'($urandom));
    end
    calm = 0;
  endtask

  // receiver: random stall per beat, plus long hold-offs on request
  initial begin
    int wait_cnt, hold_cnt, holds_seen;
    wait_cnt = 0;
    hold_cnt = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_cnt = 400;
      end
      if (m_tvalid && m_tready) wait_cnt = draw_gap();
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready = 0;
      end else if (wait_cnt > 0) begin
        wait_cnt--;
        m_tready = 0;
      end else begin
        m_tready = 1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    grid_beat_t exp_b;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: cell_out %0d clean_done %0b", m_tdata[6:0], m_tuser);
        fail_count++;
      end else begin
        exp_b = expected_beats.pop_front();
        if (m_tdata[6:0] !== exp_b.cell_val) begin
          $error("cell_out expected %0d actual %0d", exp_b.cell_val, m_tdata[6:0]);
          fail_count++;
        end
        if (m_tuser !== exp_b.done) begin
          $error("clean_done expected %0b actual %0b", exp_b.done, m_tuser);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || rst) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    dir_row_t row;
    repeat (9) @(negedge clk);
    rst = 0;

    // 3x3 grid with a lone occupied center: clean must clear it
    for (int i = 0; i < 9; i++) begin
      row = '{REQ_LOAD, (i == 4) ? 8'h80 : 8'h00, 0, CELL_FREE, 0};
      dir_rows.push_back(row);
    end
    for (int i = 0; i < 9; i++) begin
      row = '{REQ_READ, 8'hFF, 1, (i == 4) ? CELL_OCC : CELL_FREE, 0};
      dir_rows.push_back(row);
    end
    dir_rows.push_back('{REQ_NONE, 8'h7F, 0, CELL_FREE, 0});
    dir_rows.push_back('{REQ_CLEAN, 8'h01, 1, CELL_FREE, 1});
    for (int i = 0; i < 5; i++) dir_rows.push_back('{REQ_READ, 8'h00, 0, CELL_FREE, 0});

    write_dims(3, 3);
    foreach (dir_rows[i]) send_typed(dir_rows[i]);

    run_phase(8, 8, 30);
    hold_next = 1;
    run_phase(8, 8, 60);
    run_phase(0, 5, 40);
    run_phase(256, 1, 60);
    run_phase(1, 256, 60);
    run_phase(3, 511, 50);
    run_phase(5, 7, 60);
    run_phase(12, 10, 60);
    run_phase(16, 16, 60);
    run_phase(3, 3, 50);
    run_phase(6, 6, 60);

    s_tvalid = 0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/gscc_pkg.sv
hdl/gscc_ram.sv
hdl/gscc_clean.sv
hdl/grid_small_cluster_cleaner_top.sv
sim/tb_top.sv
